// ----- rtl/ptc_pkg.sv -----
// Shared types, constants and helpers of the pressure and temperature compensation block.
package ptc_pkg;

    // Converter resolution: only the top RawWidth bits of the sample are used.
    localparam int SampleBits = 20;
    localparam int RawWidth   = 20;
    localparam logic [SampleBits-1:0] RawMask =
        SampleBits'(~((64'd1 << (SampleBits - RawWidth)) - 64'd1));

    // Fixed constants of the compensation formulae.
    localparam logic [63:0] TOffset = 64'd128000;
    localparam logic [63:0] PBase   = 64'd1048576;
    localparam logic [63:0] PScale  = 64'd3125;
    localparam logic [63:0] PBias   = 64'd1 << 47;

    // Configuration register indexes.
    localparam logic [1:0] CfgTemp   = 2'd0;
    localparam logic [1:0] CfgPressA = 2'd1;
    localparam logic [1:0] CfgPressB = 2'd2;
    localparam logic [1:0] CfgPressC = 2'd3;

    // Calibration coefficients as seen by the datapath.
    typedef struct packed {
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] t3;
        logic [15:0] p1;
        logic [15:0] p2;
        logic [15:0] p3;
        logic [15:0] p4;
        logic [15:0] p5;
        logic [15:0] p6;
        logic [15:0] p7;
        logic [15:0] p8;
        logic [15:0] p9;
    } t_cal;

    // One result word.
    typedef struct packed {
        logic        kind;
        logic [31:0] temp;
        logic [31:0] press;
        logic        zdiv;
    } t_res;

    // Sequencer states and micro-program steps.
    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_DONE
    } t_state;

    typedef enum logic [3:0] {
        ST_TD1,
        ST_TD2,
        ST_TT3,
        ST_PSQ,
        ST_PA,
        ST_PB,
        ST_PC,
        ST_PD,
        ST_PE,
        ST_PN,
        ST_PQ,
        ST_PF,
        ST_PG,
        ST_PH
    } t_step;

    // Sign extension of a 16-bit coefficient to 64 bits.
    function automatic logic [63:0] sx16(input logic [15:0] f);
        return {{48{f[15]}}, f};
    endfunction

endpackage

// ----- rtl/pressure_temperature_compensation_top.sv -----
// Top level of the pressure and temperature compensation block.
// Each accepted word is one raw sample: action 0 gives the compensated temperature in
// 0.01 degC and stores the fine temperature, action 1 gives pressure in Q24.8 pascals
// from the stored fine temperature. All arithmetic runs on one bit-serial 64-bit
// multiplier and one bit-serial divider, one operation at a time: a temperature word needs
// three products, a pressure word ten products and one division, or six products when
// the divisor is zero. One word is worked on at a time; the next is accepted while a
// result waits in the output register.
module pressure_temperature_compensation_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_action,
    input  logic [19:0] i_raw_sample,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_result_kind,
    output logic [31:0] o_temperature_centi,
    output logic [31:0] o_pressure_q24_8,
    output logic        o_zero_divisor,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import ptc_pkg::*;

    logic [47:0] r_tcal;
    logic [63:0] r_pcal_a;
    logic [63:0] r_pcal_b;
    logic [15:0] r_pcal_c;
    logic        r_out_valid;
    t_res        r_out;
    t_cal        w_cal;
    t_res        w_res;
    logic        w_idle;
    logic        w_res_valid;
    logic        w_take;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tcal   <= '0;
            r_pcal_a <= '0;
            r_pcal_b <= '0;
            r_pcal_c <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CfgTemp:   r_tcal   <= i_cfg_data[47:0];
                CfgPressA: r_pcal_a <= i_cfg_data;
                CfgPressB: r_pcal_b <= i_cfg_data;
                CfgPressC: r_pcal_c <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    assign w_cal = '{
        t1: r_tcal[15:0],    t2: r_tcal[31:16],   t3: r_tcal[47:32],
        p1: r_pcal_a[15:0],  p2: r_pcal_a[31:16], p3: r_pcal_a[47:32],
        p4: r_pcal_a[63:48], p5: r_pcal_b[15:0],  p6: r_pcal_b[31:16],
        p7: r_pcal_b[47:32], p8: r_pcal_b[63:48], p9: r_pcal_c
    };

    ptc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_in_valid && w_idle),
        .i_action    (i_action),
        .i_adc       (i_raw_sample & RawMask),
        .i_cal       (w_cal),
        .i_take      (w_take),
        .o_idle      (w_idle),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    assign o_in_ready = w_idle;

    // Output register: a finished word moves in when the slot is free or being emptied.
    assign w_take = w_res_valid && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_result_kind       = r_out.kind;
    assign o_temperature_centi = r_out.temp;
    assign o_pressure_q24_8    = r_out.press;
    assign o_zero_divisor      = r_out.zdiv;
endmodule

// ----- rtl/ptc_mul.sv -----
// Bit-serial 64 by 64 multiplier giving the low 64 bits of the product.
module ptc_mul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_prod
);
    import ptc_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_a;
    logic [63:0] r_b;
    logic [63:0] r_acc;

    // Control: 64 steps, one multiplier bit each.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Shift-and-add datapath.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= {r_a[62:0], 1'b0};
            r_b <= {1'b0, r_b[63:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

// ----- rtl/ptc_div.sv -----
// Bit-serial signed 64-bit divider, truncating toward zero.
module ptc_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quot
);
    import ptc_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic        r_neg;
    logic [63:0] r_rem;
    logic [63:0] r_qt;
    logic [63:0] r_d;
    logic [64:0] w_rem_s;
    logic [64:0] w_diff;
    logic        w_ge;

    // One restoring step: shift in the next dividend bit and try a subtract.
    assign w_rem_s = {r_rem, r_qt[63]};
    assign w_diff  = w_rem_s - {1'b0, r_d};
    assign w_ge    = w_rem_s >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Magnitudes are taken at the start; the sign is put back at the output.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[63] ^ i_den[63];
            r_qt  <= i_num[63] ? (64'd0 - i_num) : i_num;
            r_d   <= i_den[63] ? (64'd0 - i_den) : i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[63:0] : w_rem_s[63:0];
            r_qt  <= {r_qt[62:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? (64'd0 - r_qt) : r_qt;
endmodule

// ----- rtl/ptc_core.sv -----
// Sequencer and working registers that run the compensation formulae on the serial units.
module ptc_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic                    i_action,
    input  logic [19:0]             i_adc,
    input  ptc_pkg::t_cal           i_cal,
    input  logic                    i_take,
    output logic                    o_idle,
    output logic                    o_res_valid,
    output ptc_pkg::t_res           o_res
);
    import ptc_pkg::*;

    t_state      r_state, n_state;
    t_step       r_step, n_step;
    logic [19:0] r_adc, n_adc;
    logic [31:0] r_fine, n_fine;
    logic [63:0] r_sq, n_sq;
    logic [63:0] r_v2, n_v2;
    logic [63:0] r_c, n_c;
    logic [63:0] r_q, n_q;
    t_res        r_res, n_res;

    logic        w_mul_start;
    logic        w_div_start;
    logic [63:0] w_op_a;
    logic [63:0] w_op_b;
    logic        w_mul_done;
    logic        w_div_done;
    logic [63:0] w_mul_prod;
    logic [63:0] w_quot;
    logic signed [63:0] w_prod;
    logic signed [63:0] w_tf;
    logic [63:0] w_v1;
    logic [63:0] w_p;
    logic [63:0] w_d1;
    logic [63:0] w_d2;
    logic [63:0] w_den;
    logic [63:0] w_tsum;
    logic [63:0] w_fin;
    logic [31:0] w_fine;

    ptc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_op_a),
        .i_b     (w_op_b),
        .o_done  (w_mul_done),
        .o_prod  (w_mul_prod)
    );

    ptc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_op_a),
        .i_den   (w_op_b),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // Operand terms that are cheap enough to form on the fly.
    assign w_prod = $signed(w_mul_prod);
    assign w_tf   = $signed({{32{r_fine[31]}}, r_fine});
    assign w_v1   = w_tf - TOffset;
    assign w_p    = PBase - {44'd0, r_adc};
    assign w_d1   = {47'd0, r_adc[19:3]} - {47'd0, i_cal.t1, 1'b0};
    assign w_d2   = {48'd0, r_adc[19:4]} - {48'd0, i_cal.t1};
    assign w_den  = w_prod >>> 33;
    assign w_fine = 32'(r_c + 64'(w_prod >>> 14));
    assign w_tsum = ({{32{w_fine[31]}}, w_fine} << 2) + {{32{w_fine[31]}}, w_fine} + 64'd128;
    assign w_fin  = 64'($signed(r_v2 + 64'(w_prod >>> 19)) >>> 8) + (sx16(i_cal.p7) << 4);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= ST_TD1;
            r_fine  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_fine  <= n_fine;
        end
    end

    always_ff @(posedge i_clk) begin
        r_adc <= n_adc;
        r_sq  <= n_sq;
        r_v2  <= n_v2;
        r_c   <= n_c;
        r_q   <= n_q;
        r_res <= n_res;
    end

    // Next state, operand selection and result write-back.
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_adc       = r_adc;
        n_fine      = r_fine;
        n_sq        = r_sq;
        n_v2        = r_v2;
        n_c         = r_c;
        n_q         = r_q;
        n_res       = r_res;
        w_mul_start = 1'b0;
        w_div_start = 1'b0;
        w_op_a      = r_sq;
        w_op_b      = r_c;

        case (r_step)
            ST_TD1: begin w_op_a = w_d1; w_op_b = sx16(i_cal.t2); end
            ST_TD2: begin w_op_a = w_d2; w_op_b = w_d2; end
            ST_TT3: begin w_op_a = r_sq; w_op_b = sx16(i_cal.t3); end
            ST_PSQ: begin w_op_a = w_v1; w_op_b = w_v1; end
            ST_PA:  begin w_op_a = r_sq; w_op_b = sx16(i_cal.p6); end
            ST_PB:  begin w_op_a = w_v1; w_op_b = sx16(i_cal.p5); end
            ST_PC:  begin w_op_a = r_sq; w_op_b = sx16(i_cal.p3); end
            ST_PD:  begin w_op_a = w_v1; w_op_b = sx16(i_cal.p2); end
            ST_PE:  begin w_op_a = PBias + r_c; w_op_b = {48'd0, i_cal.p1}; end
            ST_PN:  begin w_op_a = (w_p << 31) - r_v2; w_op_b = PScale; end
            ST_PQ:  begin w_op_a = r_sq; w_op_b = r_c; end
            ST_PF:  begin w_op_a = sx16(i_cal.p9); w_op_b = $signed(r_q) >>> 13; end
            ST_PG:  begin w_op_a = r_c; w_op_b = $signed(r_q) >>> 13; end
            ST_PH:  begin w_op_a = sx16(i_cal.p8); w_op_b = r_q; end
            default: begin w_op_a = r_sq; w_op_b = r_c; end
        endcase

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_adc       = i_adc;
                    n_res       = '0;
                    n_res.kind  = i_action;
                    n_step      = i_action ? ST_PSQ : ST_TD1;
                    n_state     = S_ISSUE;
                end
            end
            S_ISSUE: begin
                if (r_step == ST_PQ) begin
                    w_div_start = 1'b1;
                end else begin
                    w_mul_start = 1'b1;
                end
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (w_mul_done || w_div_done) begin
                    n_state = S_ISSUE;
                    case (r_step)
                        ST_TD1: begin n_c = w_prod >>> 11; n_step = ST_TD2; end
                        ST_TD2: begin n_sq = w_prod >>> 12; n_step = ST_TT3; end
                        ST_TT3: begin
                            n_fine     = w_fine;
                            n_res.temp = w_tsum[39:8];
                            n_state    = S_DONE;
                        end
                        ST_PSQ: begin n_sq = w_prod; n_step = ST_PA; end
                        ST_PA:  begin n_v2 = w_prod; n_step = ST_PB; end
                        ST_PB: begin
                            n_v2   = r_v2 + (w_prod << 17) + (sx16(i_cal.p4) << 35);
                            n_step = ST_PC;
                        end
                        ST_PC:  begin n_c = w_prod >>> 8; n_step = ST_PD; end
                        ST_PD:  begin n_c = r_c + (w_prod << 12); n_step = ST_PE; end
                        ST_PE: begin
                            n_c = w_den;
                            if (w_den == 64'd0) begin
                                n_res.zdiv = 1'b1;
                                n_state    = S_DONE;
                            end else begin
                                n_step = ST_PN;
                            end
                        end
                        ST_PN:  begin n_sq = w_prod; n_step = ST_PQ; end
                        ST_PQ:  begin n_q = w_quot; n_step = ST_PF; end
                        ST_PF:  begin n_c = w_prod; n_step = ST_PG; end
                        ST_PG:  begin n_v2 = r_q + 64'(w_prod >>> 25); n_step = ST_PH; end
                        ST_PH: begin
                            n_res.press = w_fin[31:0];
                            n_state     = S_DONE;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;
endmodule

// ----- rtl/ptc_checker.sv -----
// Port-level checks of the compensation block, bound to its top level.
module ptc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_result_kind,
    input logic [31:0] o_temperature_centi,
    input logic [31:0] o_pressure_q24_8,
    input logic        o_zero_divisor
);
    // A waiting result word is not withdrawn.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result word dropped while stalled");

    // A zero divisor only comes with a pressure word whose value is zero.
    a_zdiv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_zero_divisor |-> o_result_kind && o_pressure_q24_8 == 32'd0)
        else $error("zero divisor flag on a malformed word");

    // A temperature word leaves the pressure fields clear.
    a_temp_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_result_kind |-> o_pressure_q24_8 == 32'd0 && !o_zero_divisor)
        else $error("temperature word carries pressure fields");

    // A pressure word leaves the temperature field clear.
    a_press_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind |-> o_temperature_centi == 32'd0)
        else $error("pressure word carries a temperature");

    // Work on one sample at a time: no acceptance on the cycle after one.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second sample accepted while busy");
endmodule

bind pressure_temperature_compensation_top ptc_checker u_ptc_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_valid          (i_in_valid),
    .o_in_ready          (o_in_ready),
    .o_out_valid         (o_out_valid),
    .i_out_ready         (i_out_ready),
    .o_result_kind       (o_result_kind),
    .o_temperature_centi (o_temperature_centi),
    .o_pressure_q24_8    (o_pressure_q24_8),
    .o_zero_divisor      (o_zero_divisor)
);

// ----- bench/tb_pressure_temperature_compensation_top.sv -----
// Self-checking testbench of the pressure and temperature compensation block.
module tb_pressure_temperature_compensation_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ptc_pkg::*;

    localparam logic ActTemp  = 1'b0;
    localparam logic ActPress = 1'b1;

    typedef struct {
        logic        kind;
        logic [31:0] temp;
        logic [31:0] press;
        logic        zdiv;
    } t_comp_word;

    // Scoreboard: own copy of the calibration and the fine temperature, and the
    // queue of compensated words still awaited from the block.
    class t_compensation_scoreboard;
        logic [47:0] temp_cal;
        logic [63:0] press_a;
        logic [63:0] press_b;
        logic [15:0] press_c;
        logic [31:0] fine_temp;
        t_comp_word  awaited[$];
        int          errors;

        function new();
            temp_cal  = '0;
            press_a   = '0;
            press_b   = '0;
            press_c   = '0;
            fine_temp = '0;
            errors    = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [63:0] data);
            case (idx)
                CfgTemp:   temp_cal = data[47:0];
                CfgPressA: press_a  = data;
                CfgPressB: press_b  = data;
                CfgPressC: press_c  = data[15:0];
                default: ;
            endcase
        endfunction

        function logic [63:0] sext(logic [15:0] f);
            return {{48{f[15]}}, f};
        endfunction

        function logic [63:0] shr(logic [63:0] x, int n);
            return $unsigned($signed(x) >>> n);
        endfunction

        // Signed quotient truncated toward zero, wrapping on overflow.
        function logic [63:0] quotient(logic [63:0] a, logic [63:0] b);
            logic [63:0] ma;
            logic [63:0] mb;
            logic [63:0] q;
            ma = a[63] ? 64'd0 - a : a;
            mb = b[63] ? 64'd0 - b : b;
            q  = ma / mb;
            return (a[63] != b[63]) ? 64'd0 - q : q;
        endfunction

        // Works out the compensated word for one accepted sample.
        function void note_sample(logic act, logic [19:0] raw);
            t_comp_word  w;
            logic [63:0] adc, t1, d1, d2, v1, v2, tf, t, p, sum, a;
            adc = {44'd0, raw & RawMask};
            tf  = {{32{fine_temp[31]}}, fine_temp};
            w.kind  = act;
            w.temp  = '0;
            w.press = '0;
            w.zdiv  = 1'b0;
            if (act == ActTemp) begin
                t1  = {48'd0, temp_cal[15:0]};
                d1  = (adc >> 3) - (t1 << 1);
                v1  = shr(d1 * sext(temp_cal[31:16]), 11);
                d2  = (adc >> 4) - t1;
                v2  = shr(shr(d2 * d2, 12) * sext(temp_cal[47:32]), 14);
                sum = v1 + v2;
                fine_temp = sum[31:0];
                tf  = {{32{fine_temp[31]}}, fine_temp};
                t   = shr(tf * 64'd5 + 64'd128, 8);
                w.temp = t[31:0];
            end else begin
                v1 = tf - TOffset;
                v2 = v1 * v1 * sext(press_b[31:16]);
                v2 = v2 + ((v1 * sext(press_b[15:0])) << 17);
                v2 = v2 + (sext(press_a[63:48]) << 35);
                v1 = shr(v1 * v1 * sext(press_a[47:32]), 8)
                     + ((v1 * sext(press_a[31:16])) << 12);
                v1 = shr((PBias + v1) * {48'd0, press_a[15:0]}, 33);
                if (v1 == 64'd0) begin
                    w.zdiv = 1'b1;
                end else begin
                    p  = PBase - adc;
                    p  = quotient(((p << 31) - v2) * PScale, v1);
                    a  = shr(p, 13);
                    v1 = shr(sext(press_c) * a * a, 25);
                    v2 = shr(sext(press_b[63:48]) * p, 19);
                    p  = shr(p + v1 + v2, 8) + (sext(press_b[47:32]) << 4);
                    w.press = p[31:0];
                end
            end
            awaited.push_back(w);
        endfunction

        // Compares one word from the block with the oldest awaited word.
        function void check_result(logic kind, logic [31:0] temp, logic [31:0] press,
                                   logic zdiv);
            t_comp_word w;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected word kind %0d", $time, kind);
                errors++;
                return;
            end
            w = awaited.pop_front();
            if (kind !== w.kind) begin
                $display("%0t: kind expected %0d actual %0d", $time, w.kind, kind);
                errors++;
            end
            if (temp !== w.temp) begin
                $display("%0t: temperature expected %h actual %h", $time, w.temp, temp);
                errors++;
            end
            if (press !== w.press) begin
                $display("%0t: pressure expected %h actual %h", $time, w.press, press);
                errors++;
            end
            if (zdiv !== w.zdiv) begin
                $display("%0t: zero divisor expected %0d actual %0d", $time, w.zdiv, zdiv);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_action;
    logic [19:0] i_raw_sample;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_result_kind;
    logic [31:0] o_temperature_centi;
    logic [31:0] o_pressure_q24_8;
    logic        o_zero_divisor;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [63:0] i_cfg_data;

    t_compensation_scoreboard sb = new();
    int burst_left;
    int stall_pct;
    int stall_span;

    pressure_temperature_compensation_top DUT (.*);

    // Clock.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: readiness follows a stall rate that changes every so often.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_result_kind, o_temperature_centi, o_pressure_q24_8,
                            o_zero_divisor);
        if (stall_span == 0) begin
            stall_span <= $urandom_range(50, 600);
            stall_pct  <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 90);
        end else begin
            stall_span <= stall_span - 1;
        end
        i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Sends one sample word, then idles now and then between bursts.
    task automatic send_sample(logic act, logic [19:0] raw);
        i_in_valid   <= 1'b1;
        i_action     <= act;
        i_raw_sample <= raw;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_sample(act, raw);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 7);
            if ($urandom_range(0, 2) != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    endtask

    // Writes one calibration register once the block has drained.
    task automatic write_cal(logic [1:0] idx, logic [63:0] data);
        i_in_valid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic load_cal(logic [47:0] tc, logic [63:0] pa, logic [63:0] pb,
                            logic [15:0] pc);
        write_cal(CfgTemp, {16'd0, tc});
        write_cal(CfgPressA, pa);
        write_cal(CfgPressB, pb);
        write_cal(CfgPressC, {48'd0, pc});
    endtask

    // Random traffic: mostly a temperature word followed by a few pressure
    // words near typical readings, with some fully random words mixed in.
    task automatic random_traffic(int count);
        int sent;
        logic [19:0] raw;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 4) == 0) begin
                send_sample(1'($urandom_range(0, 1)), 20'($urandom_range(0, 20'hFFFFF)));
                sent++;
            end else begin
                raw = 20'(20'd519888 + $urandom_range(0, 40000) - 20000);
                send_sample(ActTemp, raw);
                sent++;
                repeat ($urandom_range(1, 4)) begin
                    raw = 20'(20'd415148 + $urandom_range(0, 100000) - 50000);
                    send_sample(ActPress, raw);
                    sent++;
                end
            end
        end
    endtask

    // Main sequence.
    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_action     = ActTemp;
        i_raw_sample = '0;
        i_out_ready  = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CfgTemp;
        i_cfg_data   = '0;
        stall_pct    = 0;
        stall_span   = 0;
        burst_left   = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset calibration: the divisor is zero for every pressure word.
        send_sample(ActPress, 20'd0);
        send_sample(ActTemp, 20'hFFFFF);
        send_sample(ActPress, 20'hFFFFF);

        // Typical sensor calibration with extreme and typical samples.
        load_cal({16'hFC18, 16'd26435, 16'd27504},
                 {16'd2855, 16'd3024, 16'hD643, 16'd36477},
                 {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140}, 16'd6000);
        send_sample(ActTemp, 20'd0);
        send_sample(ActPress, 20'd0);
        send_sample(ActPress, 20'hFFFFF);
        send_sample(ActTemp, 20'hFFFFF);
        send_sample(ActPress, 20'd415148);
        send_sample(ActTemp, 20'd519888);
        send_sample(ActPress, 20'd415148);
        send_sample(ActPress, 20'hAAAAA);
        send_sample(ActTemp, 20'h55555);
        random_traffic(300);

        // A zero first pressure coefficient forces a zero divisor.
        write_cal(CfgPressA, {16'd2855, 16'd3024, 16'hD643, 16'd0});
        send_sample(ActPress, 20'd415148);
        random_traffic(60);

        // All coefficients at their largest patterns.
        load_cal('1, '1, '1, '1);
        send_sample(ActTemp, 20'hFFFFF);
        send_sample(ActPress, 20'd0);
        send_sample(ActTemp, 20'd0);
        send_sample(ActPress, 20'hFFFFF);
        random_traffic(150);

        // Signed extremes of each coefficient.
        load_cal({16'h8000, 16'h8000, 16'hFFFF}, {16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF},
                 {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}, 16'h8000);
        random_traffic(150);

        // Random calibration sets.
        repeat (3) begin
            load_cal(48'({$urandom, $urandom}), {$urandom, $urandom},
                     {$urandom, $urandom}, 16'($urandom));
            random_traffic(150);
        end

        i_in_valid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (1000) @(posedge i_clk);
        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("tb_pressure_temperature_compensation_top passed");
        else
            $display("tb_pressure_temperature_compensation_top failed");
        $finish;
    end

    // Watchdog.
    initial begin
        #40ms;
        $display("tb_pressure_temperature_compensation_top failed");
        $finish;
    end

endmodule
